>>> src/ctsl_pkg.sv
// Package for the C subset token lexer: token codes, pending classes, tables, shared types.
`default_nettype none
package ctsl_pkg;

    localparam int OFFSET_BITS = 16;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
    localparam int KIND_BITS = 6;
    localparam int TDATA_W = ((KIND_BITS + 2 * OFFSET_BITS + 7) / 8) * 8;
    localparam int NUM_KW = 6;
    localparam int KW_CHARS = 8;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [KIND_BITS-1:0] t_kind;

    localparam t_kind K_EOF    = 6'd0;
    localparam t_kind K_NUM    = 6'd1;
    localparam t_kind K_ID     = 6'd2;
    localparam t_kind K_INT    = 6'd3;
    localparam t_kind K_INC    = 6'd9;
    localparam t_kind K_ADDEQ  = 6'd10;
    localparam t_kind K_PLUS   = 6'd11;
    localparam t_kind K_DEC    = 6'd12;
    localparam t_kind K_SUBEQ  = 6'd13;
    localparam t_kind K_MINUS  = 6'd14;
    localparam t_kind K_STAR   = 6'd15;
    localparam t_kind K_SLASH  = 6'd16;
    localparam t_kind K_PCT    = 6'd17;
    localparam t_kind K_LPAR   = 6'd18;
    localparam t_kind K_RPAR   = 6'd19;
    localparam t_kind K_LBRK   = 6'd20;
    localparam t_kind K_RBRK   = 6'd21;
    localparam t_kind K_EQEQ   = 6'd22;
    localparam t_kind K_ASSIGN = 6'd23;
    localparam t_kind K_OROR   = 6'd24;
    localparam t_kind K_OR     = 6'd25;
    localparam t_kind K_ANDAND = 6'd26;
    localparam t_kind K_AND    = 6'd27;
    localparam t_kind K_XOR    = 6'd28;
    localparam t_kind K_SHL    = 6'd29;
    localparam t_kind K_LT     = 6'd30;
    localparam t_kind K_SHR    = 6'd31;
    localparam t_kind K_GT     = 6'd32;
    localparam t_kind K_SEMI   = 6'd33;
    localparam t_kind K_COMMA  = 6'd34;
    localparam t_kind K_LBRC   = 6'd35;
    localparam t_kind K_RBRC   = 6'd36;
    localparam t_kind K_ERR    = 6'd37;

    // keywords in token code order: int if else for break continue
    localparam logic [7:0] KW_CHR [NUM_KW][KW_CHARS] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "t", "i", "n", "u", "e"}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd3, 4'd2, 4'd4, 4'd3, 4'd5, 4'd8};

    typedef enum logic [9:0] {
        PC_NONE  = 10'b00_0000_0001,
        PC_NUM   = 10'b00_0000_0010,
        PC_ID    = 10'b00_0000_0100,
        PC_PLUS  = 10'b00_0000_1000,
        PC_MINUS = 10'b00_0001_0000,
        PC_EQ    = 10'b00_0010_0000,
        PC_OR    = 10'b00_0100_0000,
        PC_AND   = 10'b00_1000_0000,
        PC_LT    = 10'b01_0000_0000,
        PC_GT    = 10'b10_0000_0000
    } t_pcls;

    typedef struct packed {
        t_kind                  kind;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] len;
        logic                   ovf;
    } t_token;

    // one accepted beat's results: tok0 always, tok1 when two is set
    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic t_pcls op_class(input logic [7:0] b);
        t_pcls c;
        unique case (b)
            "+":     c = PC_PLUS;
            "-":     c = PC_MINUS;
            "=":     c = PC_EQ;
            "|":     c = PC_OR;
            "&":     c = PC_AND;
            "<":     c = PC_LT;
            ">":     c = PC_GT;
            default: c = PC_NONE;
        endcase
        return c;
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] b);
        t_kind k;
        unique case (b)
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "%":     k = K_PCT;
            "(":     k = K_LPAR;
            ")":     k = K_RPAR;
            "[":     k = K_LBRK;
            "]":     k = K_RBRK;
            "^":     k = K_XOR;
            ";":     k = K_SEMI;
            ",":     k = K_COMMA;
            "{":     k = K_LBRC;
            "}":     k = K_RBRC;
            default: k = K_ERR;
        endcase
        return k;
    endfunction

    function automatic t_kind single_kind(input t_pcls c);
        t_kind k;
        unique case (c)
            PC_PLUS:  k = K_PLUS;
            PC_MINUS: k = K_MINUS;
            PC_EQ:    k = K_ASSIGN;
            PC_OR:    k = K_OR;
            PC_AND:   k = K_AND;
            PC_LT:    k = K_LT;
            default:  k = K_GT;
        endcase
        return k;
    endfunction

    // K_EOF means the byte does not pair with the pending operator
    function automatic t_kind pair_kind(input t_pcls c, input logic [7:0] b);
        t_kind k;
        k = K_EOF;
        unique case (c)
            PC_PLUS:  k = (b == "+") ? K_INC : ((b == "=") ? K_ADDEQ : K_EOF);
            PC_MINUS: k = (b == "-") ? K_DEC : ((b == "=") ? K_SUBEQ : K_EOF);
            PC_EQ:    k = (b == "=") ? K_EQEQ : K_EOF;
            PC_OR:    k = (b == "|") ? K_OROR : K_EOF;
            PC_AND:   k = (b == "&") ? K_ANDAND : K_EOF;
            PC_LT:    k = (b == "<") ? K_SHL : K_EOF;
            PC_GT:    k = (b == ">") ? K_SHR : K_EOF;
            default:  k = K_EOF;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

>>> src/ctsl_front.sv
// Front end: takes text beats, keeps the pending token and forms result records.
`default_nettype none
module ctsl_front
    import ctsl_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire logic   [7:0] i_byte,
    input  wire logic   i_eot,
    output logic        o_ready,
    input  wire t_qstat i_qstat,
    output logic        o_push,
    output t_rec        o_rec
);

    t_pcls                  r_pcls, n_pcls;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_pstart, n_pstart;
    logic [OFFSET_BITS-1:0] r_plen, n_plen;
    logic [NUM_KW-1:0]      r_kw, n_kw;
    logic                   r_ovf_seen, n_ovf_seen;
    logic                   r_povf, n_povf;

    logic   acc;
    t_token ptok;
    t_token stok;
    t_token eoftok;
    t_kind  pk;
    t_kind  pairk;
    t_pcls  opc;
    logic   dig, alp, spc, single;

    assign o_ready = !i_qstat.full;
    assign acc     = i_valid && o_ready;

    assign dig   = is_digit(i_byte);
    assign alp   = is_alpha(i_byte);
    assign spc   = is_space(i_byte);
    assign opc   = op_class(i_byte);
    assign pairk = pair_kind(r_pcls, i_byte);
    assign single = !dig && !alp && !spc && (opc == PC_NONE);

    // kind of the pending token if it closed now
    always_comb begin
        if (r_pcls == PC_NUM) begin
            pk = K_NUM;
        end else if (r_pcls == PC_ID) begin
            pk = K_ID;
            for (int k = NUM_KW - 1; k >= 0; k--) begin
                if (r_kw[k] && (r_plen == OFFSET_BITS'(KW_LEN[k]))) begin
                    pk = K_INT + KIND_BITS'(k);
                end
            end
        end else begin
            pk = single_kind(r_pcls);
        end
    end

    assign ptok   = '{kind: pk, start: r_pstart, len: r_plen, ovf: r_povf};
    assign stok   = '{kind: punct_kind(i_byte), start: r_pos,
                      len: OFFSET_BITS'(1), ovf: r_ovf_seen};
    assign eoftok = '{kind: K_EOF, start: r_pos, len: '0, ovf: r_ovf_seen};

    always_comb begin
        n_pcls     = r_pcls;
        n_pos      = r_pos;
        n_pstart   = r_pstart;
        n_plen     = r_plen;
        n_kw       = r_kw;
        n_ovf_seen = r_ovf_seen;
        n_povf     = r_povf;
        o_push     = 1'b0;
        o_rec      = '{tok0: ptok, tok1: eoftok, two: 1'b0};
        if (acc) begin
            if (i_eot) begin
                o_push = 1'b1;
                if (r_pcls != PC_NONE) begin
                    o_rec.two = 1'b1;
                end else begin
                    o_rec.tok0 = eoftok;
                end
                n_pcls     = PC_NONE;
                n_pos      = '0;
                n_pstart   = '0;
                n_plen     = '0;
                n_kw       = '1;
                n_ovf_seen = 1'b0;
                n_povf     = 1'b0;
            end else begin
                priority if ((r_pcls == PC_NUM && dig) || (r_pcls == PC_ID && (alp || dig))) begin
                    if (r_pcls == PC_ID) begin
                        for (int k = 0; k < NUM_KW; k++) begin
                            if ((r_plen >= OFFSET_BITS'(KW_LEN[k])) ||
                                (KW_CHR[k][r_plen[2:0]] != i_byte)) begin
                                n_kw[k] = 1'b0;
                            end
                        end
                    end
                    if (r_plen == POS_MAX) begin
                        n_povf = 1'b1;
                    end else begin
                        n_plen = r_plen + 1'b1;
                    end
                end else if (pairk != K_EOF) begin
                    o_push = 1'b1;
                    o_rec.tok0 = '{kind: pairk, start: r_pstart,
                                   len: OFFSET_BITS'(2), ovf: r_povf};
                    n_pcls = PC_NONE;
                end else begin
                    // pending token closes; the byte may also give a token of its own
                    if (r_pcls != PC_NONE) begin
                        o_push = 1'b1;
                        n_pcls = PC_NONE;
                        if (single) begin
                            o_rec.two  = 1'b1;
                            o_rec.tok1 = stok;
                        end
                    end else if (single) begin
                        o_push     = 1'b1;
                        o_rec.tok0 = stok;
                    end
                    if (dig || alp || (opc != PC_NONE)) begin
                        n_pcls   = dig ? PC_NUM : (alp ? PC_ID : opc);
                        n_pstart = r_pos;
                        n_plen   = OFFSET_BITS'(1);
                        n_povf   = r_ovf_seen;
                    end
                    if (alp) begin
                        for (int k = 0; k < NUM_KW; k++) begin
                            n_kw[k] = (KW_CHR[k][0] == i_byte);
                        end
                    end
                end
                if (r_pos == POS_MAX) begin
                    n_ovf_seen = 1'b1;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcls     <= PC_NONE;
            r_pos      <= '0;
            r_pstart   <= '0;
            r_plen     <= '0;
            r_kw       <= '1;
            r_ovf_seen <= 1'b0;
            r_povf     <= 1'b0;
        end else begin
            r_pcls     <= n_pcls;
            r_pos      <= n_pos;
            r_pstart   <= n_pstart;
            r_plen     <= n_plen;
            r_kw       <= n_kw;
            r_ovf_seen <= n_ovf_seen;
            r_povf     <= n_povf;
        end
    end

    a_eot_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_eot) |=> (r_pos == '0 && r_pcls == PC_NONE && !r_ovf_seen))
        else $error("position not restarted after end of text");

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf_seen && !(acc && i_eot)) |=> (r_pos == POS_MAX && r_ovf_seen))
        else $error("saturated position moved");

endmodule
`default_nettype wire

>>> src/ctsl_queue.sv
// Short record queue between front and back ends.
`default_nettype none
module ctsl_queue
    import ctsl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_rec i_rec,
    input  wire logic i_pop,
    output t_rec      o_head,
    output t_qstat    o_qstat
);

    t_rec              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_qstat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_head        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_qstat.full))
        else $error("record pushed into full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_qstat.empty))
        else $error("record popped from empty queue");

endmodule
`default_nettype wire

>>> src/ctsl_back.sv
// Back end: unpacks queued records into single tokens behind an output register.
`default_nettype none
module ctsl_back
    import ctsl_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_rec   i_head,
    input  wire t_qstat i_qstat,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_token      o_tok,
    output logic        o_last
);

    logic   r_vld;
    logic   r_sub;
    t_token r_tok;
    logic   r_last;
    logic   load;

    assign load  = (!r_vld || i_ready) && !i_qstat.empty;
    assign o_pop = load && (r_sub || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_sub <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
            r_sub <= !o_pop;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= r_sub ? i_head.tok1 : i_head.tok0;
            r_last <= r_sub || !i_head.two;
        end
    end

    assign o_valid = r_vld;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

    // second token of a record always follows its first with last clear
    a_sub_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !r_sub && i_head.two) |=> (r_sub && !r_last))
        else $error("first of two tokens flagged last");

endmodule
`default_nettype wire

>>> src/c_subset_token_lexer_top.sv
// Top level of the C subset token lexer.
// Source text arrives one byte per beat on s_axis; tlast marks the end of text, which
// flushes any pending token, emits EOF and restarts the offset count at zero. Tokens leave
// on m_axis as kind, start offset and length, with tuser set when an offset or length has
// saturated and tlast on the final token caused by an input beat. One input beat is taken
// per cycle while the four-record queue between the classifier and the output stage has
// room; the output stage sends one token per cycle while m_axis_tready is high, so a byte
// that yields two tokens holds it for both and sustained throughput is set by that stage.
// A token passes from its input beat through the queue memory and the output register.
`default_nettype none
module c_subset_token_lexer_top
    import ctsl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // text_byte
    input  wire logic               s_axis_tlast,   // end_of_text
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // token_kind, start_offset, token_length, zero pad
    output logic                    m_axis_tuser,   // position_overflow
    output logic                    m_axis_tlast    // last_of_run
);

    t_qstat qstat;
    logic   push, pop;
    t_rec   rec, head;
    t_token tok;

    ctsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_eot   (s_axis_tlast),
        .o_ready (s_axis_tready),
        .i_qstat (qstat),
        .o_push  (push),
        .o_rec   (rec)
    );

    ctsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    ctsl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (tok),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = TDATA_W'({tok.len, tok.start, tok.kind});
    assign m_axis_tuser = tok.ovf;

endmodule
`default_nettype wire
